// ===== hw/rtl/slcpd_pkg.sv =====
// Shared types, constants and the CRC fold function of the deframer.
package slcpd_pkg;

  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [7:0] SYNC_BYTE = 8'hF0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PACKET_SIZE = 2'd0,
    REG_CRC_ENABLE  = 2'd1,
    REG_CRC_POLY    = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    K_TAKEN   = 3'd0,
    K_REFUSED = 3'd1,
    K_CRCERR  = 3'd2,
    K_PAYLOAD = 3'd3,
    K_NONE    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_SYNC,
    PH_DATA,
    PH_CRCHI,
    PH_CRCLO,
    PH_READY,
    PH_READOUT
  } phase_t;

  typedef struct packed {
    logic load_len;
    logic store;
    logic xor_hi;
    logic rd_start;
    logic rd_step;
    logic emit;
    kind_t kind;
    logic ready_flag;
  } dp_cmd_t;

  typedef struct packed {
    logic take;
    logic is_sync;
    logic len_ok;
    logic data_done;
    logic crc_en;
    logic crc_match;
    logic slot_free;
  } dp_status_t;

  // MSB-first, unreflected CRC-16 update with one byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] d,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/slcpd_if.sv =====
// Request channel interfaces: serial input items and result items.
interface slcpd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface slcpd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] payload_byte;
  logic       last;
  logic       frame_ready;
  logic       sent_notice;

  modport source (output valid, output kind, output payload_byte, output last,
                  output frame_ready, output sent_notice, input ready);
  modport sink (input valid, input kind, input payload_byte, input last,
                input frame_ready, input sent_notice, output ready);
endinterface

// ===== hw/rtl/slcpd_ctrl.sv =====
// Deframer controller: frame phase state machine and datapath commands.
module slcpd_ctrl
  import slcpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  input  logic       rd_last,
  output dp_cmd_t    cmd
);

  phase_t state, state_next;
  logic   fire;

  assign in_ready = (state != PH_READOUT) && status.slot_free;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (state == PH_READOUT) begin
      if (status.slot_free && rd_last) begin
        state_next = PH_WAIT;
      end
    end else if (fire) begin
      if (status.take) begin
        if (state == PH_READY) begin
          state_next = PH_READOUT;
        end
      end else begin
        unique case (state)
          PH_WAIT:  state_next = status.is_sync ? PH_SYNC : PH_WAIT;
          PH_SYNC: begin
            if (status.len_ok) begin
              state_next = PH_DATA;
            end else if (!status.is_sync) begin
              state_next = PH_WAIT;
            end
          end
          PH_DATA: begin
            if (status.data_done) begin
              state_next = status.crc_en ? PH_CRCHI : PH_READY;
            end
          end
          PH_CRCHI: state_next = PH_CRCLO;
          PH_CRCLO: state_next = status.crc_match ? PH_READY : PH_WAIT;
          PH_READY: state_next = PH_READY;
          default:  state_next = PH_WAIT;
        endcase
      end
    end
  end

  always_comb begin
    cmd = '0;
    cmd.kind = K_TAKEN;
    cmd.ready_flag = (state_next == PH_READY);
    if (state == PH_READOUT) begin
      cmd.rd_step = status.slot_free;
      cmd.emit    = status.slot_free;
      cmd.kind    = K_PAYLOAD;
      cmd.ready_flag = 1'b0;
    end else if (fire) begin
      if (status.take) begin
        if (state == PH_READY) begin
          cmd.rd_start = 1'b1;
        end else begin
          cmd.emit = 1'b1;
          cmd.kind = K_NONE;
          cmd.ready_flag = 1'b0;
        end
      end else begin
        cmd.emit = 1'b1;
        unique case (state)
          PH_SYNC:  cmd.load_len = status.len_ok;
          PH_DATA:  cmd.store = 1'b1;
          PH_CRCHI: cmd.xor_hi = 1'b1;
          PH_CRCLO: cmd.kind = status.crc_match ? K_TAKEN : K_CRCERR;
          PH_READY: cmd.kind = K_REFUSED;
          default:  cmd.kind = K_TAKEN;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/slcpd_datapath.sv =====
// Deframer datapath: config, counters, CRC, payload memory and result register.
module slcpd_datapath
  import slcpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_opcode,
  input  logic [7:0]            in_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic                  rd_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_kind,
  output logic [7:0]            out_payload,
  output logic                  out_last,
  output logic                  out_frame_ready,
  output logic                  out_sent
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [6:0]       packet_size;
  logic             crc_enable;
  logic [15:0]      crc_poly;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] frame_length;
  logic [15:0]      running_crc;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] addr_sel;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       rdata;
  logic [7:0]       mem [MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_size <= 7'd64;
      crc_enable  <= 1'b1;
      crc_poly    <= 16'h1021;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PACKET_SIZE: packet_size <= cfg_data[6:0];
        REG_CRC_ENABLE:  crc_enable  <= cfg_data[0];
        REG_CRC_POLY:    crc_poly    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count_inc = byte_count + CNT_W'(1);

  assign status.take      = in_opcode;
  assign status.is_sync   = (in_data == SYNC_BYTE);
  assign status.len_ok    = (in_data != 8'd0) && (in_data < {1'b0, packet_size})
                            && (in_data <= 8'(MAX_PAYLOAD));
  assign status.data_done = (count_inc >= frame_length);
  assign status.crc_en    = crc_enable;
  assign status.crc_match = (running_crc == {8'h00, in_data});
  assign status.slot_free = !out_valid || out_ready;

  assign rd_last = ((rd_idx + CNT_W'(1)) == frame_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      frame_length <= '0;
      running_crc  <= '0;
    end else if (cmd.load_len) begin
      byte_count   <= '0;
      frame_length <= in_data[CNT_W-1:0];
      running_crc  <= '0;
    end else if (cmd.store) begin
      byte_count <= count_inc;
      if (crc_enable) begin
        running_crc <= crc_fold(running_crc, in_data, crc_poly);
      end
    end else if (cmd.xor_hi) begin
      running_crc <= running_crc ^ {in_data, 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[byte_count[AW-1:0]] <= in_data;
    end
  end

  always_comb begin
    if (cmd.rd_start) begin
      addr_sel = '0;
    end else if (cmd.rd_step) begin
      addr_sel = rd_idx + CNT_W'(1);
    end else begin
      addr_sel = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else begin
      rd_idx <= addr_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (addr_sel < CNT_W'(MAX_PAYLOAD)) begin
      rdata <= mem[addr_sel[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind        <= cmd.kind;
      out_frame_ready <= cmd.ready_flag;
      if (cmd.rd_step) begin
        out_payload <= rdata;
        out_last    <= rd_last;
        out_sent    <= rd_last;
      end else begin
        out_payload <= 8'h00;
        out_last    <= 1'b1;
        out_sent    <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/sync_length_crc_packet_deframer.sv =====
// Top level: sync/length/payload/CRC-16 deframer with held-frame readout.
// A serial byte or an empty take gives its one result in the cycle after acceptance.
// Throughput: one serial byte per cycle while the result register drains each cycle.
// A take of a held frame gives frame_length results, one per cycle while results drain,
// set by the single read port of the payload memory; no input is accepted during readout.
// Synchronous active-high reset: sync wait, counters and CRC cleared, config to defaults.
module sync_length_crc_packet_deframer
  import slcpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  slcpd_in_if.sink              bytes,
  slcpd_out_if.source           results
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       rd_last;

  slcpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_ready (bytes.ready),
    .status   (status),
    .rd_last  (rd_last),
    .cmd      (cmd)
  );

  slcpd_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_opcode       (bytes.opcode),
    .in_data         (bytes.data_byte),
    .cmd             (cmd),
    .status          (status),
    .rd_last         (rd_last),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_kind        (results.kind),
    .out_payload     (results.payload_byte),
    .out_last        (results.last),
    .out_frame_ready (results.frame_ready),
    .out_sent        (results.sent_notice)
  );

  a_byte_result: assert property (@(posedge clk) disable iff (rst)
    bytes.valid && bytes.ready && !bytes.opcode |=> results.valid && results.last)
    else $error("serial byte did not give a single final result");

  a_readout_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_step |-> !bytes.ready)
    else $error("input accepted during frame readout");

  a_sent_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.sent_notice |-> results.last && results.kind == K_PAYLOAD)
    else $error("sent notice on a result that is not the final payload byte");

endmodule
